>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define MHB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define MHB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mhb_pkg.sv
package mhb_pkg;

  localparam logic [31:0] MIX_MUL = 32'h5bd1_e995;

  localparam int unsigned WORD_SHIFT = 24;
  localparam int unsigned FIN_SH_A   = 18;
  localparam int unsigned FIN_SH_B   = 22;
  localparam int unsigned FIN_SH_C   = 17;
  localparam int unsigned FIN_SH_D   = 19;

  // Request kinds carried in tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  typedef logic [31:0] word_t;

endpackage

>>> rtl/murmur_hash64b_stream.sv
// Channel   | Dir | Transfer                  | Payload
// ----------+-----+---------------------------+--------------------------------------
// s_axis    | in  | tvalid & tready           | tuser: req_type; tdata: msg_len, data_word
// m_axis    | out | tvalid & tready           | tdata: hash_value
// cfg       | in  | we high at clock edge     | wdata: hash_seed
//
// A start loads the lanes from seed and length. A full data word runs on the shared
// multiplier in steps (mix, mix, lane multiply, combine); a tail word takes one multiply.
// Finishing runs four mixing rounds on the same multiplier plus hand-off;
// zero-length start goes straight to finishing.
// rst_ni is asynchronous, active low; it clears seed, lanes and all control.
// s_axis_tready_o is high only while idle. A finished hash waits in the
// hand-off state while the output register still holds an untaken hash.
module murmur_hash64b_stream
  import mhb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,    // hash_seed
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i, // [31:0] msg_len, [63:32] data_word
  input  logic        s_axis_tuser_i, // [0] req_type
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o  // [63:0] hash_value
);

`include "assert_macros.svh"

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_W1   = 11'b000_0000_0010,  // k ^= k >> 24, multiply again
    ST_W2   = 11'b000_0000_0100,  // hold k, multiply lane
    ST_W3   = 11'b000_0000_1000,  // lane = lane*M ^ k
    ST_T1   = 11'b000_0001_0000,  // tail product into lane two
    ST_F0   = 11'b000_0010_0000,
    ST_F1   = 11'b000_0100_0000,
    ST_F2   = 11'b000_1000_0000,
    ST_F3   = 11'b001_0000_0000,
    ST_F4   = 11'b010_0000_0000,
    ST_DONE = 11'b100_0000_0000   // wait for the output register
  } state_e;

  state_e state_q, state_d;
  logic [63:0] seed_q;
  word_t lane1_q, lane1_d, lane2_q, lane2_d, k_q, k_d;
  word_t bytes_q, bytes_d;
  logic  parity_q, parity_d, open_q, open_d;
  logic  out_valid_q, out_valid_d;
  logic [63:0] out_data_q, out_data_d;

  word_t mul_op, prod;
  word_t len_w, data_w, tail_w;
  logic  s_xfer, m_xfer;

  assign len_w  = s_axis_tdata_i[31:0];
  assign data_w = s_axis_tdata_i[63:32];
  assign s_xfer = s_axis_tvalid_i & s_axis_tready_o;
  assign m_xfer = out_valid_q & m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Tail bytes only: the masked word is used only when bytes_q is 1..3
  always_comb begin
    case (bytes_q[1:0])
      2'd3:    tail_w = data_w & 32'h00ff_ffff;
      2'd2:    tail_w = data_w & 32'h0000_ffff;
      default: tail_w = data_w & 32'h0000_00ff;
    endcase
  end

  mhb_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  always_comb begin
    state_d     = state_q;
    lane1_d     = lane1_q;
    lane2_d     = lane2_q;
    k_d         = k_q;
    bytes_d     = bytes_q;
    parity_d    = parity_q;
    open_d      = open_q;
    out_valid_d = out_valid_q & ~m_xfer;
    out_data_d  = out_data_q;
    mul_op      = data_w;

    case (state_q)
      ST_IDLE: begin
        if (bytes_q < 32'd4) begin
          mul_op = lane2_q ^ tail_w;
        end
        if (s_xfer) begin
          if (s_axis_tuser_i == REQ_START) begin
            lane1_d  = seed_q[31:0] ^ len_w;
            lane2_d  = seed_q[63:32];
            bytes_d  = len_w;
            parity_d = 1'b0;
            open_d   = (len_w != 32'd0);
            if (len_w == 32'd0) begin
              state_d = ST_F0;
            end
          end else if (open_q) begin
            if (bytes_q >= 32'd4) begin
              bytes_d = bytes_q - 32'd4;
              open_d  = (bytes_q != 32'd4);
              state_d = ST_W1;
            end else begin
              bytes_d = '0;
              open_d  = 1'b0;
              state_d = ST_T1;
            end
          end
        end
      end
      ST_W1: begin
        mul_op  = prod ^ (prod >> WORD_SHIFT);
        state_d = ST_W2;
      end
      ST_W2: begin
        mul_op  = parity_q ? lane2_q : lane1_q;
        k_d     = prod;
        state_d = ST_W3;
      end
      ST_W3: begin
        if (parity_q) begin
          lane2_d = prod ^ k_q;
        end else begin
          lane1_d = prod ^ k_q;
        end
        parity_d = ~parity_q;
        state_d  = (bytes_q == 32'd0) ? ST_F0 : ST_IDLE;
      end
      ST_T1: begin
        lane2_d = prod;
        state_d = ST_F0;
      end
      // Cross-mixing rounds; each new lane value comes straight off the product
      ST_F0: begin
        mul_op  = lane1_q ^ (lane2_q >> FIN_SH_A);
        state_d = ST_F1;
      end
      ST_F1: begin
        lane1_d = prod;
        mul_op  = lane2_q ^ (prod >> FIN_SH_B);
        state_d = ST_F2;
      end
      ST_F2: begin
        lane2_d = prod;
        mul_op  = lane1_q ^ (prod >> FIN_SH_C);
        state_d = ST_F3;
      end
      ST_F3: begin
        lane1_d = prod;
        mul_op  = lane2_q ^ (prod >> FIN_SH_D);
        state_d = ST_F4;
      end
      ST_F4: begin
        lane2_d = prod;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {lane1_q, lane2_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= '0;
      lane1_q     <= '0;
      lane2_q     <= '0;
      k_q         <= '0;
      bytes_q     <= '0;
      parity_q    <= 1'b0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane1_q     <= lane1_d;
      lane2_q     <= lane2_d;
      k_q         <= k_d;
      bytes_q     <= bytes_d;
      parity_q    <= parity_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  `MHB_ASSERT(a_open_has_bytes, !open_q || (bytes_q != 32'd0), "open message with no bytes left")
  `MHB_ASSERT_NEXT(a_zero_len_fin, s_xfer && (s_axis_tuser_i == REQ_START) && (len_w == 32'd0), (state_q == ST_F0) && !open_q, "zero length start did not finish")
  `MHB_ASSERT_NEXT(a_word_seq, s_xfer && (s_axis_tuser_i == REQ_DATA) && open_q && (bytes_q >= 32'd4), state_q == ST_W1, "full word did not enter mixing")
  `MHB_ASSERT(a_out_from_done, !$rose(out_valid_q) || ($past(state_q) == ST_DONE), "hash shown outside hand-off")

endmodule

>>> rtl/mhb_mul.sv
// Shared constant multiplier, product registered (low 32 bits).
module mhb_mul
  import mhb_pkg::*;
(
  input  logic  clk_i,
  input  word_t op_i,
  output word_t prod_o
);

  word_t prod_d, prod_q;

  assign prod_d = op_i * MIX_MUL;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule
